// ----- rtl/sbqm_pkg.sv -----
// Shared types and constants for the stereo biquad cascade with dry/wet mix.
// Used by the top level, the multiplier and the port checker; no dependencies.

package sbqm_pkg;

  // Fixed widths of the transaction fields and of the datapath
  localparam int SAMPLE_BITS   = 24;
  localparam int COEF_BITS     = 32;
  localparam int COEF_IDX_BITS = 5;
  localparam int GUARD_BITS    = 8;
  localparam int DLY_BITS      = 48;
  localparam int MIX_BITS      = 17;
  localparam int MIX_FRAC      = 16;
  localparam logic [MIX_BITS-1:0] MIX_ONE = MIX_BITS'(65536);

  // Shared multiplier: coefficient or mix fraction times sample or sample difference
  localparam int MUL_A_BITS = COEF_BITS;
  localparam int MUL_B_BITS = SAMPLE_BITS + 1;
  localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
  localparam int ACC_BITS   = PROD_BITS + 1;

  // Defaults for the top-level parameters
  localparam int SECTIONS_DEF  = 4;
  localparam int COEF_FRAC_DEF = 28;

  // Configuration port
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam logic REG_MIX    = 1'b0;
  localparam logic REG_BYPASS = 1'b1;

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_COEF   = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef struct packed {
    req_t                           req_type;
    logic signed [SAMPLE_BITS-1:0]  left_in;
    logic signed [SAMPLE_BITS-1:0]  right_in;
    logic [COEF_IDX_BITS-1:0]       coef_index;
    logic signed [COEF_BITS-1:0]    coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } out_item_t;

endpackage

// ----- rtl/sbqm_mult.sv -----
// Shared signed multiplier with a registered product.
// Depends on sbqm_pkg for operand and product widths.

module sbqm_mult (
  input  logic                                     clk,
  input  logic signed [sbqm_pkg::MUL_A_BITS-1:0]   mul_a,
  input  logic signed [sbqm_pkg::MUL_B_BITS-1:0]   mul_b,
  output logic signed [sbqm_pkg::PROD_BITS-1:0]    prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

endmodule

// ----- rtl/stereo_biquad_cascade_mix_top.sv -----
// Stereo biquad cascade, four sections by default (transposed DF-II), Q16 dry/wet mix.
// Depends on sbqm_pkg and sbqm_mult; coefficient and delay stores live here.
//
//   channel | direction | handshake               | payload
//   in_     | input     | in_valid / in_stall     | sbqm_pkg::in_item_t
//   out_    | output    | out_valid / out_stall   | sbqm_pkg::out_item_t
//   cfg_    | input     | APB psel/penable/pready | mix fraction, bypass flag
//
// A filtered sample runs states S0 to S5 once per section and channel, then FIN, the
// blend states (skipped when the mix is fully wet) and DONE into the result register;
// the steps are set by the one shared multiplier and the single read port of each store.
// Bypassed samples go straight to DONE; coefficient writes and clears complete while idle.
// Reset needs no clearing pass: per-entry valid bits restore identity coefficients and
// zero delays at once. A waiting result holds in the output register while the next
// transaction is accepted; the input stalls while an item is in flight.

module stereo_biquad_cascade_mix_top #(
  parameter int SECTIONS       = sbqm_pkg::SECTIONS_DEF,
  parameter int COEF_FRAC_BITS = sbqm_pkg::COEF_FRAC_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  sbqm_pkg::in_item_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output sbqm_pkg::out_item_t                    out_data,
  input  logic                                   cfg_psel,
  input  logic                                   cfg_penable,
  input  logic                                   cfg_pwrite,
  input  logic [sbqm_pkg::CFG_ADDR_BITS-1:0]     cfg_paddr,
  input  logic [sbqm_pkg::CFG_DATA_BITS-1:0]     cfg_pwdata,
  output logic [sbqm_pkg::CFG_DATA_BITS-1:0]     cfg_prdata,
  output logic                                   cfg_pready
);

  localparam int SB    = sbqm_pkg::SAMPLE_BITS;
  localparam int CB    = sbqm_pkg::COEF_BITS;
  localparam int DB    = sbqm_pkg::DLY_BITS;
  localparam int AB    = sbqm_pkg::ACC_BITS;
  localparam int MB    = sbqm_pkg::MUL_B_BITS;
  localparam int MXB   = sbqm_pkg::MIX_BITS;
  localparam int NCOEF = SECTIONS * 5;
  localparam int NDLY  = SECTIONS * 4;
  localparam int CA_W  = $clog2(NCOEF);
  localparam int DA_W  = $clog2(NDLY);
  localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int IDX_W = sbqm_pkg::COEF_IDX_BITS + 1;
  localparam int PSHIFT = COEF_FRAC_BITS - sbqm_pkg::GUARD_BITS;

  localparam logic [IDX_W-1:0]     NCOEF_CMP = IDX_W'(NCOEF);
  localparam logic [SEC_W-1:0]     SEC_LAST  = SEC_W'(SECTIONS - 1);
  localparam logic [CA_W-1:0]      SEC_STEP  = CA_W'(5);
  localparam logic signed [CB-1:0] COEF_ONE  = CB'(64'sd1 <<< COEF_FRAC_BITS);

  localparam logic signed [AB-1:0] P_HALF = AB'(1) <<< (PSHIFT - 1);
  localparam logic signed [AB-1:0] G_HALF = AB'(1) <<< (sbqm_pkg::GUARD_BITS - 1);
  localparam logic signed [AB-1:0] M_HALF = AB'(1) <<< (sbqm_pkg::MIX_FRAC - 1);
  localparam logic signed [AB-1:0] SMAX_A = AB'((64'sd1 <<< (SB - 1)) - 1);
  localparam logic signed [AB-1:0] SMIN_A = -SMAX_A - 1;
  localparam logic signed [AB-1:0] DMAX_A = AB'((64'sd1 <<< (DB - 1)) - 1);
  localparam logic signed [AB-1:0] DMIN_A = -DMAX_A - 1;

  // Coefficient positions within a section
  localparam logic [2:0] POS_B0 = 3'd0;
  localparam logic [2:0] POS_B1 = 3'd1;
  localparam logic [2:0] POS_B2 = 3'd2;
  localparam logic [2:0] POS_A1 = 3'd3;
  localparam logic [2:0] POS_A2 = 3'd4;

  // Delay word within a section and channel
  localparam logic DLY_Z1 = 1'b0;
  localparam logic DLY_Z2 = 1'b1;

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b000_0000_0001,
    ST_S0      = 11'b000_0000_0010,
    ST_S1      = 11'b000_0000_0100,
    ST_S2      = 11'b000_0000_1000,
    ST_S3      = 11'b000_0001_0000,
    ST_S4      = 11'b000_0010_0000,
    ST_S5      = 11'b000_0100_0000,
    ST_FIN     = 11'b000_1000_0000,
    ST_BLEND_L = 11'b001_0000_0000,
    ST_BLEND_R = 11'b010_0000_0000,
    ST_DONE    = 11'b100_0000_0000
  } state_t;

  function automatic logic signed [SB-1:0] sat_sample(input logic signed [AB-1:0] v);
    priority if (v > SMAX_A) return SMAX_A[SB-1:0];
    else if (v < SMIN_A)     return SMIN_A[SB-1:0];
    else                     return v[SB-1:0];
  endfunction

  function automatic logic signed [DB-1:0] sat_dly(input logic signed [AB-1:0] v);
    priority if (v > DMAX_A) return DMAX_A[DB-1:0];
    else if (v < DMIN_A)     return DMIN_A[DB-1:0];
    else                     return v[DB-1:0];
  endfunction

  // Control state
  state_t             state_r, state_nxt;
  logic [SEC_W-1:0]   sec_r, sec_nxt;
  logic               ch_r, ch_nxt;
  logic [CA_W-1:0]    cbase_r, cbase_nxt;
  logic               pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [MXB-1:0]     mix_r, mix_nxt;
  logic               bypass_r, bypass_nxt;

  // Datapath registers
  logic signed [SB-1:0] x_r, x_nxt;
  logic signed [SB-1:0] y_r, y_nxt;
  logic signed [DB-1:0] z1_r, z1_nxt;
  logic signed [DB-1:0] z2_r, z2_nxt;
  logic signed [AB-1:0] acc_r, acc_nxt;
  logic signed [SB-1:0] wet_l_r, wet_l_nxt;
  logic signed [SB-1:0] dry_l_r, dry_l_nxt;
  logic signed [SB-1:0] dry_r_r, dry_r_nxt;
  logic signed [SB-1:0] res_l_r, res_l_nxt;
  logic signed [SB-1:0] res_r_r, res_r_nxt;
  logic [DA_W-1:0]      wz2_addr_r, wz2_addr_nxt;
  sbqm_pkg::out_item_t  out_r, out_nxt;

  // Coefficient store
  logic signed [CB-1:0] cmem [NCOEF];
  logic [NCOEF-1:0]     cvalid_r;
  logic signed [CB-1:0] coef_rd_r;
  logic                 cval_rd_r;
  logic                 cdef_rd_r;
  logic                 c_rd_en, c_rd_b0, c_wr_en;
  logic [CA_W-1:0]      c_rd_addr, c_wr_addr;
  logic signed [CB-1:0] c_wr_data;
  logic signed [CB-1:0] coef_q;

  // Delay store
  logic signed [DB-1:0] dmem [NDLY];
  logic [NDLY-1:0]      dvalid_r;
  logic signed [DB-1:0] dly_rd_r;
  logic                 dval_rd_r;
  logic                 d_rd_en, d_wr_en, d_clear;
  logic [DA_W-1:0]      d_rd_addr, d_wr_addr;
  logic signed [DB-1:0] d_wr_data;
  logic signed [DB-1:0] dly_q;
  logic [DA_W-1:0]      d_addr_z1, d_addr_z2;

  // Multiplier and arithmetic
  logic signed [sbqm_pkg::MUL_A_BITS-1:0] mul_a;
  logic signed [MB-1:0]                   mul_b;
  logic signed [sbqm_pkg::PROD_BITS-1:0]  prod;
  logic signed [AB-1:0]                   p_rnd, y_sum, mix_p;
  logic signed [SB-1:0]                   y_calc, blend_l, blend_r;
  logic signed [DB-1:0]                   z1_new, z2_new;
  logic signed [MB-1:0]                   diff_l, diff_r;
  logic                                   in_take;

  sbqm_mult u_mult (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod)
  );

  assign in_stall   = (state_r != ST_IDLE);
  assign in_take    = in_valid && !in_stall;
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;
  assign cfg_pready = 1'b1;

  always_comb begin
    if (cfg_paddr[2] == sbqm_pkg::REG_BYPASS) begin
      cfg_prdata = sbqm_pkg::CFG_DATA_BITS'(bypass_r);
    end else begin
      cfg_prdata = sbqm_pkg::CFG_DATA_BITS'(mix_r);
    end
  end

  always_comb begin
    mix_nxt    = mix_r;
    bypass_nxt = bypass_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      unique case (cfg_paddr[2])
        sbqm_pkg::REG_MIX:    mix_nxt    = cfg_pwdata[MXB-1:0];
        sbqm_pkg::REG_BYPASS: bypass_nxt = cfg_pwdata[0];
        default:              mix_nxt    = mix_r;
      endcase
    end
  end

  // Never-written entries read as their reset value
  assign coef_q = cval_rd_r ? coef_rd_r : (cdef_rd_r ? COEF_ONE : '0);
  assign dly_q  = dval_rd_r ? dly_rd_r : '0;

  assign d_addr_z1 = DA_W'({sec_r, ch_r, DLY_Z1});
  assign d_addr_z2 = DA_W'({sec_r, ch_r, DLY_Z2});

  assign p_rnd  = (AB'(prod) + P_HALF) >>> PSHIFT;
  assign y_sum  = (p_rnd + AB'(z1_r) + G_HALF) >>> sbqm_pkg::GUARD_BITS;
  assign y_calc = sat_sample(y_sum);
  assign z1_new = sat_dly(acc_r - p_rnd + AB'(z2_r));
  assign z2_new = sat_dly(acc_r - p_rnd);
  assign mix_p  = (AB'(prod) + M_HALF) >>> sbqm_pkg::MIX_FRAC;
  assign blend_l = sat_sample(AB'(dry_l_r) + mix_p);
  assign blend_r = sat_sample(AB'(dry_r_r) + mix_p);
  assign diff_l = MB'(wet_l_r) - MB'(dry_l_r);
  assign diff_r = MB'(y_r) - MB'(dry_r_r);

  always_comb begin
    state_nxt     = state_r;
    sec_nxt       = sec_r;
    ch_nxt        = ch_r;
    cbase_nxt     = cbase_r;
    pend_nxt      = pend_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    z1_nxt        = z1_r;
    z2_nxt        = z2_r;
    acc_nxt       = acc_r;
    wet_l_nxt     = wet_l_r;
    dry_l_nxt     = dry_l_r;
    dry_r_nxt     = dry_r_r;
    res_l_nxt     = res_l_r;
    res_r_nxt     = res_r_r;
    wz2_addr_nxt  = wz2_addr_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    c_rd_en   = 1'b0;
    c_rd_b0   = 1'b0;
    c_rd_addr = cbase_r;
    c_wr_en   = 1'b0;
    c_wr_addr = CA_W'(in_data.coef_index);
    c_wr_data = in_data.coef_value;
    d_rd_en   = 1'b0;
    d_rd_addr = d_addr_z1;
    d_wr_en   = 1'b0;
    d_wr_addr = wz2_addr_r;
    d_wr_data = z2_new;
    d_clear   = 1'b0;
    mul_a     = coef_q;
    mul_b     = MB'(x_r);

    // Drop the result once the receiver takes it
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          unique case (in_data.req_type)
            sbqm_pkg::REQ_SAMPLE: begin
              dry_l_nxt = in_data.left_in;
              dry_r_nxt = in_data.right_in;
              if (bypass_r || (mix_r == '0)) begin
                res_l_nxt = in_data.left_in;
                res_r_nxt = in_data.right_in;
                state_nxt = ST_DONE;
              end else begin
                x_nxt     = in_data.left_in;
                sec_nxt   = '0;
                ch_nxt    = 1'b0;
                cbase_nxt = '0;
                pend_nxt  = 1'b0;
                state_nxt = ST_S0;
              end
            end
            sbqm_pkg::REQ_COEF: begin
              c_wr_en = ({1'b0, in_data.coef_index} < NCOEF_CMP);
            end
            sbqm_pkg::REQ_CLEAR: begin
              d_clear = 1'b1;
            end
            sbqm_pkg::REQ_NONE: begin
              d_clear = 1'b0;
            end
          endcase
        end
      end
      ST_S0: begin
        // Fetch b0 and z1; retire z2 of the previous section
        c_rd_en   = 1'b1;
        c_rd_b0   = 1'b1;
        c_rd_addr = cbase_r + CA_W'(POS_B0);
        d_rd_en   = 1'b1;
        d_rd_addr = d_addr_z1;
        d_wr_en   = pend_r;
        pend_nxt  = 1'b0;
        state_nxt = ST_S1;
      end
      ST_S1: begin
        z1_nxt    = dly_q;
        c_rd_en   = 1'b1;
        c_rd_addr = cbase_r + CA_W'(POS_B1);
        d_rd_en   = 1'b1;
        d_rd_addr = d_addr_z2;
        state_nxt = ST_S2;
      end
      ST_S2: begin
        y_nxt     = y_calc;
        z2_nxt    = dly_q;
        c_rd_en   = 1'b1;
        c_rd_addr = cbase_r + CA_W'(POS_A1);
        state_nxt = ST_S3;
      end
      ST_S3: begin
        acc_nxt   = p_rnd;
        mul_b     = MB'(y_r);
        c_rd_en   = 1'b1;
        c_rd_addr = cbase_r + CA_W'(POS_B2);
        state_nxt = ST_S4;
      end
      ST_S4: begin
        d_wr_en      = 1'b1;
        d_wr_addr    = d_addr_z1;
        d_wr_data    = z1_new;
        wz2_addr_nxt = d_addr_z2;
        c_rd_en      = 1'b1;
        c_rd_addr    = cbase_r + CA_W'(POS_A2);
        state_nxt    = ST_S5;
      end
      ST_S5: begin
        acc_nxt  = p_rnd;
        mul_b    = MB'(y_r);
        pend_nxt = 1'b1;
        priority if (sec_r != SEC_LAST) begin
          sec_nxt   = sec_r + 1'b1;
          cbase_nxt = cbase_r + SEC_STEP;
          x_nxt     = y_r;
          state_nxt = ST_S0;
        end else if (!ch_r) begin
          wet_l_nxt = y_r;
          ch_nxt    = 1'b1;
          sec_nxt   = '0;
          cbase_nxt = '0;
          x_nxt     = dry_r_r;
          state_nxt = ST_S0;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // Retire the last z2; y_r holds the right wet sample
        d_wr_en  = 1'b1;
        pend_nxt = 1'b0;
        if (mix_r >= sbqm_pkg::MIX_ONE) begin
          res_l_nxt = wet_l_r;
          res_r_nxt = y_r;
          state_nxt = ST_DONE;
        end else begin
          mul_a     = sbqm_pkg::MUL_A_BITS'(mix_r);
          mul_b     = diff_l;
          state_nxt = ST_BLEND_L;
        end
      end
      ST_BLEND_L: begin
        res_l_nxt = blend_l;
        mul_a     = sbqm_pkg::MUL_A_BITS'(mix_r);
        mul_b     = diff_r;
        state_nxt = ST_BLEND_R;
      end
      ST_BLEND_R: begin
        res_r_nxt = blend_r;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.left_out  = res_l_r;
          out_nxt.right_out = res_r_r;
          out_valid_nxt     = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sec_r       <= '0;
      ch_r        <= 1'b0;
      cbase_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      mix_r       <= sbqm_pkg::MIX_ONE;
      bypass_r    <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      sec_r       <= sec_nxt;
      ch_r        <= ch_nxt;
      cbase_r     <= cbase_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      mix_r       <= mix_nxt;
      bypass_r    <= bypass_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    z1_r       <= z1_nxt;
    z2_r       <= z2_nxt;
    acc_r      <= acc_nxt;
    wet_l_r    <= wet_l_nxt;
    dry_l_r    <= dry_l_nxt;
    dry_r_r    <= dry_r_nxt;
    res_l_r    <= res_l_nxt;
    res_r_r    <= res_r_nxt;
    wz2_addr_r <= wz2_addr_nxt;
    out_r      <= out_nxt;
  end

  // Coefficient store: written only while idle, read only while filtering
  always_ff @(posedge clk) begin
    if (c_wr_en) begin
      cmem[c_wr_addr] <= c_wr_data;
    end
    if (c_rd_en) begin
      coef_rd_r <= cmem[c_rd_addr];
      cval_rd_r <= cvalid_r[c_rd_addr];
      cdef_rd_r <= c_rd_b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cvalid_r <= '0;
    end else if (c_wr_en) begin
      cvalid_r[c_wr_addr] <= 1'b1;
    end
  end

  // Delay store: a section reads z1/z2 before it rewrites them, and the next read of
  // the same entry belongs to the next sample, so no forwarding path is needed
  always_ff @(posedge clk) begin
    if (d_wr_en) begin
      dmem[d_wr_addr] <= d_wr_data;
    end
    if (d_rd_en) begin
      dly_rd_r  <= dmem[d_rd_addr];
      dval_rd_r <= dvalid_r[d_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || d_clear) begin
      dvalid_r <= '0;
    end else if (d_wr_en) begin
      dvalid_r[d_wr_addr] <= 1'b1;
    end
  end

endmodule

// ----- rtl/sbqm_checker.sv -----
// Port-level checker for the stereo biquad cascade top level, bound to it below.
// Depends on sbqm_pkg for the transaction types and request codes.

module sbqm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input sbqm_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input sbqm_pkg::out_item_t out_data
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // A sample transaction occupies the block: the next cycle stalls the input
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.req_type == sbqm_pkg::REQ_SAMPLE |=> in_stall)
    else $error("input taken again straight after a sample");

  // Coefficient writes, clears and unused codes give no result
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.req_type != sbqm_pkg::REQ_SAMPLE && !out_valid
    |=> !out_valid)
    else $error("result raised by a non-sample transaction");

  // Leave reset idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind stereo_biquad_cascade_mix_top sbqm_checker u_sbqm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- verif/tb_top.sv -----
// Self-checking bench for stereo_biquad_cascade_mix_top: directed table, then random traffic.
// Depends on sbqm_pkg and the RTL only; expected outputs come from a predictor held here.

module tb_top;

  localparam int NUM_SECT      = sbqm_pkg::SECTIONS_DEF;
  localparam int NUM_COEF      = NUM_SECT * 5;
  localparam int PROD_SHIFT    = sbqm_pkg::COEF_FRAC_DEF - sbqm_pkg::GUARD_BITS;
  localparam int IN_BITS       = $bits(sbqm_pkg::in_item_t);
  localparam int GAP_MAX       = 19;
  localparam int SETTLE_CYCLES = 64;
  localparam int IDLE_LIMIT    = 2000;
  localparam int RANDOM_ITEMS  = 1650;
  localparam int PHASE_ITEMS   = 110;
  localparam logic [sbqm_pkg::CFG_ADDR_BITS-1:0] MIX_ADDR    = {sbqm_pkg::REG_MIX, 2'b00};
  localparam logic [sbqm_pkg::CFG_ADDR_BITS-1:0] BYPASS_ADDR = {sbqm_pkg::REG_BYPASS, 2'b00};
  localparam logic [sbqm_pkg::COEF_BITS-1:0]     COEF_ONE    =
    sbqm_pkg::COEF_BITS'(1) << sbqm_pkg::COEF_FRAC_DEF;

  typedef struct {
    bit                            is_cfg;
    logic [sbqm_pkg::MIX_BITS-1:0] mix;
    bit                            byp;
    sbqm_pkg::in_item_t            req;
    bit                            has_want;
    sbqm_pkg::out_item_t           want;
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  sbqm_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sbqm_pkg::out_item_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [sbqm_pkg::CFG_ADDR_BITS-1:0] cfg_paddr = '0;
  logic [sbqm_pkg::CFG_DATA_BITS-1:0] cfg_pwdata = '0;
  logic [sbqm_pkg::CFG_DATA_BITS-1:0] cfg_prdata;
  logic cfg_pready;

  // Predictor state
  logic signed [sbqm_pkg::COEF_BITS-1:0] coef_q [NUM_COEF];
  longint                                z_q [NUM_SECT][2][2];
  logic [sbqm_pkg::MIX_BITS-1:0]         mix_q;
  bit                                    bypass_q;

  sbqm_pkg::out_item_t expected_outputs [$];
  int mismatch_count = 0;
  int n_samples = 0;
  int n_coef = 0;
  int n_clears = 0;
  int n_settings = 0;
  int n_results = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit in_calm = 1'b0;
  bit out_calm = 1'b0;

  stereo_biquad_cascade_mix_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint shift_round(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip_bits(longint v, int bits);
    longint hi;
    hi = (longint'(1) << (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic longint coef_mul(logic signed [sbqm_pkg::COEF_BITS-1:0] c, longint s);
    return shift_round(longint'(c) * s, PROD_SHIFT);
  endfunction

  // One channel through the cascade, then the dry/wet blend; updates the delays
  function automatic longint filter_channel(int ch, longint dry);
    longint x;
    longint y;
    int s;
    x = dry;
    for (s = 0; s < NUM_SECT; s++) begin
      y = clip_bits(shift_round(coef_mul(coef_q[5*s], x) + z_q[s][ch][0],
                                sbqm_pkg::GUARD_BITS), sbqm_pkg::SAMPLE_BITS);
      z_q[s][ch][0] = clip_bits(coef_mul(coef_q[5*s+1], x) - coef_mul(coef_q[5*s+3], y)
                                + z_q[s][ch][1], sbqm_pkg::DLY_BITS);
      z_q[s][ch][1] = clip_bits(coef_mul(coef_q[5*s+2], x) - coef_mul(coef_q[5*s+4], y),
                                sbqm_pkg::DLY_BITS);
      x = y;
    end
    if (mix_q >= sbqm_pkg::MIX_ONE) return x;
    return clip_bits(dry + shift_round((x - dry) * longint'(mix_q), sbqm_pkg::MIX_FRAC),
                     sbqm_pkg::SAMPLE_BITS);
  endfunction

  // Apply one accepted transaction; returns 1 when it yields an output sample
  function automatic bit filter_and_mix(sbqm_pkg::in_item_t req, output sbqm_pkg::out_item_t res);
    longint l;
    longint r;
    int s;
    int ch;
    res = '0;
    case (req.req_type)
      sbqm_pkg::REQ_COEF: begin
        if (req.coef_index < NUM_COEF) coef_q[req.coef_index] = req.coef_value;
        return 1'b0;
      end
      sbqm_pkg::REQ_CLEAR: begin
        for (s = 0; s < NUM_SECT; s++)
          for (ch = 0; ch < 2; ch++) begin
            z_q[s][ch][0] = 0;
            z_q[s][ch][1] = 0;
          end
        return 1'b0;
      end
      sbqm_pkg::REQ_SAMPLE: begin
        l = req.left_in;
        r = req.right_in;
        if (!bypass_q && mix_q != 0) begin
          l = filter_channel(0, l);
          r = filter_channel(1, r);
        end
        res.left_out  = l[sbqm_pkg::SAMPLE_BITS-1:0];
        res.right_out = r[sbqm_pkg::SAMPLE_BITS-1:0];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic step_t row_sample(logic [sbqm_pkg::SAMPLE_BITS-1:0] l,
                                       logic [sbqm_pkg::SAMPLE_BITS-1:0] r);
    step_t s;
    s = '{default: '0};
    s.req.req_type = sbqm_pkg::REQ_SAMPLE;
    s.req.left_in  = l;
    s.req.right_in = r;
    return s;
  endfunction

  function automatic step_t row_coef(logic [sbqm_pkg::COEF_IDX_BITS-1:0] idx,
                                     logic [sbqm_pkg::COEF_BITS-1:0] v);
    step_t s;
    s = '{default: '0};
    s.req.req_type   = sbqm_pkg::REQ_COEF;
    s.req.coef_index = idx;
    s.req.coef_value = v;
    return s;
  endfunction

  function automatic step_t row_op(sbqm_pkg::req_t t);
    step_t s;
    s = '{default: '0};
    s.req = '1;
    s.req.req_type = t;
    return s;
  endfunction

  function automatic step_t row_setting(logic [sbqm_pkg::MIX_BITS-1:0] mix, bit byp);
    step_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.mix    = mix;
    s.byp    = byp;
    return s;
  endfunction

  function automatic step_t with_result(step_t s, logic [sbqm_pkg::SAMPLE_BITS-1:0] l,
                                        logic [sbqm_pkg::SAMPLE_BITS-1:0] r);
    s.has_want       = 1'b1;
    s.want.left_out  = l;
    s.want.right_out = r;
    return s;
  endfunction

  function automatic int next_gap();
    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
    return in_calm ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  function automatic logic [sbqm_pkg::SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1) ? 24'h7F_FFFF : 24'h80_0000;
      1, 2: return sbqm_pkg::SAMPLE_BITS'($urandom_range(0, 8191) - 4096);
      default: return sbqm_pkg::SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Mostly moderate coefficients so the cascade stays lively; some extremes and raw words
  function automatic logic [sbqm_pkg::COEF_BITS-1:0] pick_coef(int pos);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return (pos == 0) ? COEF_ONE : '0;
      default: begin
        if (pos < 3) return $urandom_range(0, 2 * COEF_ONE) - COEF_ONE;
        return $urandom_range(0, COEF_ONE) - (COEF_ONE >> 1);
      end
    endcase
  endfunction

  task automatic send_request(input sbqm_pkg::in_item_t req, input int gap, output bit has_res,
                              output sbqm_pkg::out_item_t res);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    has_res = filter_and_mix(req, res);
    case (req.req_type)
      sbqm_pkg::REQ_SAMPLE: n_samples++;
      sbqm_pkg::REQ_COEF:   n_coef++;
      sbqm_pkg::REQ_CLEAR:  n_clears++;
      default: ;
    endcase
  endtask

  task automatic write_reg(input logic [sbqm_pkg::CFG_ADDR_BITS-1:0] addr,
                           input logic [sbqm_pkg::CFG_DATA_BITS-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    // read the register back
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== value) begin
      $error("register readback at 0x%0h: expected 0x%0h, got 0x%0h", addr, value, cfg_prdata);
      mismatch_count++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Drain the pipeline, then reprogram mix and bypass
  task automatic change_setting(input logic [sbqm_pkg::MIX_BITS-1:0] mix, input bit byp);
    in_valid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(MIX_ADDR, sbqm_pkg::CFG_DATA_BITS'(mix));
    write_reg(BYPASS_ADDR, sbqm_pkg::CFG_DATA_BITS'(byp));
    mix_q    = mix;
    bypass_q = byp;
    n_settings++;
  endtask

  initial begin : stimulus
    step_t script [$];
    step_t row;
    sbqm_pkg::in_item_t req;
    sbqm_pkg::out_item_t res;
    bit has_res;
    int k;
    int s;
    int counted;
    int phase;
    int burst_left;
    int burst_sec;
    int kind;
    logic [sbqm_pkg::MIX_BITS-1:0] next_mix;
    bit next_byp;

    for (k = 0; k < NUM_COEF; k++) coef_q[k] = (k % 5 == 0) ? COEF_ONE : '0;
    for (s = 0; s < NUM_SECT; s++)
      for (k = 0; k < 4; k++) z_q[s][k/2][k%2] = 0;
    mix_q    = sbqm_pkg::MIX_ONE;
    bypass_q = 1'b1;

    // Out of reset the block bypasses: samples come straight back
    script.push_back(with_result(row_sample(24'h7F_FFFF, 24'h80_0000), 24'h7F_FFFF, 24'h80_0000));
    script.push_back(with_result(row_sample(24'h80_0000, 24'h7F_FFFF), 24'h80_0000, 24'h7F_FFFF));
    script.push_back(row_op(sbqm_pkg::REQ_NONE));
    script.push_back(row_coef(5'd31, 32'hFFFF_FFFF));
    script.push_back(row_coef(5'd20, 32'h7FFF_FFFF));
    script.push_back(row_op(sbqm_pkg::REQ_CLEAR));
    script.push_back(with_result(row_sample(24'h00_0000, 24'hFF_FFFF), 24'h00_0000, 24'hFF_FFFF));
    // Identity sections, fully wet
    script.push_back(row_setting(sbqm_pkg::MIX_ONE, 1'b0));
    script.push_back(with_result(row_sample(24'h7F_FFFF, 24'h80_0000), 24'h7F_FFFF, 24'h80_0000));
    // Largest and smallest gain in the first section saturate the output
    script.push_back(row_coef(5'd0, 32'h7FFF_FFFF));
    script.push_back(with_result(row_sample(24'h7F_FFFF, 24'h80_0000), 24'h7F_FFFF, 24'h80_0000));
    script.push_back(row_coef(5'd0, 32'h8000_0000));
    script.push_back(with_result(row_sample(24'h7F_FFFF, 24'h80_0000), 24'h80_0000, 24'h7F_FFFF));
    script.push_back(row_coef(5'd0, COEF_ONE));
    script.push_back(row_coef(5'd1, 32'h0800_0000));
    script.push_back(row_coef(5'd3, 32'hF800_0000));
    script.push_back(row_coef(5'd19, 32'h0400_0000));
    script.push_back(row_sample(24'h40_0000, 24'hC0_0000));
    script.push_back(row_sample(24'h12_3456, 24'hFE_DCBA));
    script.push_back(row_op(sbqm_pkg::REQ_CLEAR));
    script.push_back(row_sample(24'h40_0000, 24'hC0_0000));
    // Zero mix is dry only
    script.push_back(row_setting('0, 1'b0));
    script.push_back(with_result(row_sample(24'h7F_FFFF, 24'h80_0000), 24'h7F_FFFF, 24'h80_0000));
    script.push_back(row_setting('1, 1'b0));
    script.push_back(row_sample(24'h20_0000, 24'hE0_0000));
    script.push_back(row_setting(17'd32768, 1'b0));
    script.push_back(row_sample(24'h7F_FFFF, 24'h80_0000));
    script.push_back(row_setting(17'd1, 1'b0));
    script.push_back(row_sample(24'h55_5555, 24'hAA_AAAA));
    // Bypass with live coefficients: delays must hold
    script.push_back(row_setting(17'd65535, 1'b1));
    script.push_back(with_result(row_sample(24'h2A_AAAA, 24'hD5_5555), 24'h2A_AAAA, 24'hD5_5555));
    script.push_back(row_setting(17'd49152, 1'b0));
    script.push_back(row_sample(24'h40_0000, 24'hC0_0000));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < script.size(); k++) begin
      row = script[k];
      if (row.is_cfg) begin
        change_setting(row.mix, row.byp);
      end else begin
        send_request(row.req, next_gap(), has_res, res);
        if (has_res) expected_outputs.push_back(row.has_want ? row.want : res);
      end
    end

    counted    = 0;
    phase      = 0;
    burst_left = 0;
    burst_sec  = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted >= (phase + 1) * PHASE_ITEMS) begin
        phase++;
        next_byp = 1'b0;
        case (phase % 8)
          0: next_mix = sbqm_pkg::MIX_ONE;
          1: next_mix = sbqm_pkg::MIX_BITS'($urandom_range(1, 65535));
          2: next_mix = '0;
          3: next_mix = '1;
          4: begin
            next_mix = sbqm_pkg::MIX_BITS'($urandom_range(0, 131071));
            next_byp = 1'b1;
          end
          5: next_mix = 17'd1;
          6: next_mix = 17'd65535;
          default: begin
            next_mix = sbqm_pkg::MIX_BITS'($urandom_range(0, 131071));
            next_byp = 1'($urandom_range(0, 1));
          end
        endcase
        change_setting(next_mix, next_byp);
      end

      req = sbqm_pkg::in_item_t'(IN_BITS'({$urandom, $urandom, $urandom}));
      if (burst_left > 0) begin
        // program a whole section, b0 through a2
        req.req_type   = sbqm_pkg::REQ_COEF;
        req.coef_index = sbqm_pkg::COEF_IDX_BITS'(burst_sec * 5 + 5 - burst_left);
        req.coef_value = pick_coef(5 - burst_left);
        burst_left--;
      end else begin
        kind = $urandom_range(0, 99);
        if (kind < 4) begin
          burst_left = 5;
          burst_sec  = $urandom_range(0, NUM_SECT - 1);
          continue;
        end else if (kind < 74) begin
          req.req_type = sbqm_pkg::REQ_SAMPLE;
          req.left_in  = pick_sample();
          req.right_in = pick_sample();
        end else if (kind < 86) begin
          req.req_type   = sbqm_pkg::REQ_COEF;
          req.coef_index = sbqm_pkg::COEF_IDX_BITS'($urandom_range(0, NUM_COEF - 1));
          req.coef_value = pick_coef(req.coef_index % 5);
        end else if (kind < 92) begin
          req.req_type = sbqm_pkg::REQ_CLEAR;
        end else if (kind < 96) begin
          req.req_type   = sbqm_pkg::REQ_COEF;
          req.coef_index = sbqm_pkg::COEF_IDX_BITS'($urandom_range(NUM_COEF, 31));
        end else begin
          req.req_type = sbqm_pkg::REQ_NONE;
        end
      end

      send_request(req, next_gap(), has_res, res);
      if (has_res) expected_outputs.push_back(res);
      counted++;
    end

    in_valid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d samples, %0d coefficient writes and %0d clears across %0d mix/bypass",
             n_samples, n_coef, n_clears, n_settings);
    $display("settings; %0d output samples compared.", n_results);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Output side: compare each transaction and hold off the next one for a random spell
  always @(posedge clk) begin : result_check
    sbqm_pkg::out_item_t want;
    int n;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (expected_outputs.size() == 0) begin
        $error("output sample arrived with none expected: left_out %0d, right_out %0d",
               out_data.left_out, out_data.right_out);
        mismatch_count++;
      end else begin
        want = expected_outputs.pop_front();
        if (out_data.left_out !== want.left_out) begin
          $error("left_out: expected %0d, got %0d", want.left_out, out_data.left_out);
          mismatch_count++;
        end
        if (out_data.right_out !== want.right_out) begin
          $error("right_out: expected %0d, got %0d", want.right_out, out_data.right_out);
          mismatch_count++;
        end
      end
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      n = out_calm ? 0 : $urandom_range(0, GAP_MAX);
      stall_left <= n;
      out_stall  <= (n != 0);
    end else if (rst_n && out_valid && out_stall) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end
  end

  // Watchdog: give up when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_psel && cfg_penable && cfg_pready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timed out after %0d cycles without a transaction", IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
